// ===== hw/rtl/sar_pkg.sv =====
package sar_pkg;

    // Field widths of the transactions and registers.
    localparam int BUTTONS_W = 16;
    localparam int AXIS_W    = 8;
    localparam int STEP_W    = 4;
    localparam int CFG_W     = 7;
    localparam int TIMER_W   = 9;
    localparam int CFG_IDX_W = 2;

    // Button bits passed straight through.
    localparam int BTN_HI_BIT  = 15;
    localparam int BTN_MID_BIT = 14;
    localparam int BTN_LO_BIT  = 12;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADZONE_LIMIT = 2'd0,
        CFG_INITIAL_DELAY  = 2'd1,
        CFG_REPEAT_DELAY   = 2'd2
    } sar_cfg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] DEADZONE_RESET = 7'h1F;
    localparam logic [CFG_W-1:0] INITIAL_RESET  = 7'h14;
    localparam logic [CFG_W-1:0] REPEAT_RESET   = 7'h0A;

    typedef logic signed [TIMER_W-1:0] sar_timer_t;

    typedef struct packed {
        logic [CFG_W-1:0] deadzone_limit;
        logic [CFG_W-1:0] initial_delay;
        logic [CFG_W-1:0] repeat_delay;
    } sar_cfg_t;

    typedef struct packed {
        logic [BUTTONS_W-1:0]     buttons;
        logic signed [AXIS_W-1:0] stick_x;
        logic signed [AXIS_W-1:0] stick_y;
        logic [STEP_W-1:0]        step;
    } sar_in_t;

    typedef struct packed {
        logic button_hi;
        logic button_mid;
        logic button_lo;
        logic pulse_up;
        logic pulse_down;
        logic pulse_left;
        logic pulse_right;
    } sar_out_t;

endpackage

// ===== hw/rtl/sar_axis.sv =====
module sar_axis (
    input  logic signed [sar_pkg::AXIS_W-1:0] axis_val,
    input  logic [sar_pkg::STEP_W-1:0]        step,
    input  sar_pkg::sar_cfg_t                 cfg,
    input  sar_pkg::sar_timer_t               timer,
    output sar_pkg::sar_timer_t               timer_next,
    output logic                              pulse_pos,
    output logic                              pulse_neg
);
    import sar_pkg::*;

    logic signed [TIMER_W-1:0] val_ext;
    logic signed [TIMER_W-1:0] lim_pos;
    logic signed [TIMER_W-1:0] lim_neg;
    logic signed [TIMER_W-1:0] step_ext;
    logic signed [TIMER_W-1:0] init_pos;
    logic signed [TIMER_W-1:0] rep_pos;
    logic signed [TIMER_W-1:0] timer_dec;
    logic signed [TIMER_W-1:0] timer_inc;
    logic                      is_pos;
    logic                      is_neg;

    // Widen everything to the signed timer width before comparing.
    assign val_ext  = {{(TIMER_W-AXIS_W){axis_val[AXIS_W-1]}}, axis_val};
    assign lim_pos  = {{(TIMER_W-CFG_W){1'b0}}, cfg.deadzone_limit};
    assign lim_neg  = -lim_pos;
    assign step_ext = {{(TIMER_W-STEP_W){1'b0}}, step};
    assign init_pos = {{(TIMER_W-CFG_W){1'b0}}, cfg.initial_delay};
    assign rep_pos  = {{(TIMER_W-CFG_W){1'b0}}, cfg.repeat_delay};

    // Dead-zone test and the timer moved toward zero in either direction.
    assign is_pos    = (val_ext >= lim_pos);
    assign is_neg    = (val_ext <= lim_neg);
    assign timer_dec = timer - step_ext;
    assign timer_inc = timer + step_ext;

    // Timer update: first deflection loads the initial delay, expiry reloads
    // the repeat delay, the dead zone clears it.
    always_comb begin
        timer_next = '0;
        pulse_pos  = 1'b0;
        pulse_neg  = 1'b0;
        if (is_pos) begin
            if (timer > 0) begin
                if (timer_dec <= 0) begin
                    timer_next = rep_pos;
                    pulse_pos  = 1'b1;
                end else begin
                    timer_next = timer_dec;
                end
            end else begin
                timer_next = init_pos;
                pulse_pos  = 1'b1;
            end
        end else if (is_neg) begin
            if (timer < 0) begin
                if (timer_inc >= 0) begin
                    timer_next = -rep_pos;
                    pulse_neg  = 1'b1;
                end else begin
                    timer_next = timer_inc;
                end
            end else begin
                timer_next = -init_pos;
                pulse_neg  = 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/stick_auto_repeat_top.sv =====
// Stick auto-repeat: button pass-through and per-axis direction pulses.
// Data path: the input register, then the result register, in that order.
// Throughput: one transaction per cycle unless m_ready holds back the result;
// the axis timers are updated in the single combinational pass between the
// two registers.
// Reset: synchronous, active low; clears both timers, empties the pipeline
// and restores the configuration registers to 31, 20 and 10.
module stick_auto_repeat_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sar_pkg::sar_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sar_pkg::sar_out_t                 m_data,
    input  logic                              cfg_we,
    input  logic [sar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sar_pkg::CFG_W-1:0]         cfg_wdata
);
    import sar_pkg::*;

    sar_cfg_t   cfg_reg;
    sar_in_t    in_reg;
    logic       in_valid_reg;
    sar_out_t   out_reg;
    sar_out_t   out_next;
    logic       out_valid_reg;
    sar_timer_t vert_timer_reg;
    sar_timer_t vert_timer_next;
    sar_timer_t horiz_timer_reg;
    sar_timer_t horiz_timer_next;
    logic       advance;
    logic       pulse_up;
    logic       pulse_down;
    logic       pulse_left;
    logic       pulse_right;

    // The input stage moves on whenever the result register is free or drained.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadzone_limit <= DEADZONE_RESET;
            cfg_reg.initial_delay  <= INITIAL_RESET;
            cfg_reg.repeat_delay   <= REPEAT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEADZONE_LIMIT: cfg_reg.deadzone_limit <= cfg_wdata;
                CFG_INITIAL_DELAY:  cfg_reg.initial_delay  <= cfg_wdata;
                CFG_REPEAT_DELAY:   cfg_reg.repeat_delay   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Vertical axis: positive is up.
    sar_axis u_vert (
        .axis_val   (in_reg.stick_y),
        .step       (in_reg.step),
        .cfg        (cfg_reg),
        .timer      (vert_timer_reg),
        .timer_next (vert_timer_next),
        .pulse_pos  (pulse_up),
        .pulse_neg  (pulse_down)
    );

    // Horizontal axis: positive is right.
    sar_axis u_horiz (
        .axis_val   (in_reg.stick_x),
        .step       (in_reg.step),
        .cfg        (cfg_reg),
        .timer      (horiz_timer_reg),
        .timer_next (horiz_timer_next),
        .pulse_pos  (pulse_right),
        .pulse_neg  (pulse_left)
    );

    // Assemble the result transaction.
    always_comb begin
        out_next.button_hi   = in_reg.buttons[BTN_HI_BIT];
        out_next.button_mid  = in_reg.buttons[BTN_MID_BIT];
        out_next.button_lo   = in_reg.buttons[BTN_LO_BIT];
        out_next.pulse_up    = pulse_up;
        out_next.pulse_down  = pulse_down;
        out_next.pulse_left  = pulse_left;
        out_next.pulse_right = pulse_right;
    end

    // Timers change only when an item leaves the input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vert_timer_reg  <= '0;
            horiz_timer_reg <= '0;
        end else if (in_valid_reg && advance) begin
            vert_timer_reg  <= vert_timer_next;
            horiz_timer_reg <= horiz_timer_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== dv/tb_stick_auto_repeat_top.sv =====
`timescale 1ns / 100ps

module tb_stick_auto_repeat_top;
    import sar_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Next state of one axis: the new timer value and the pulses it causes.
    typedef struct packed {
        logic signed [15:0] timer;
        logic               pos;
        logic               neg;
    } axis_next_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sar_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sar_out_t m_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DEADZONE_LIMIT;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Frames waiting to be sent and the outputs predicted for accepted frames.
    sar_in_t  frames_to_send[$];
    sar_out_t predicted_outputs[$];

    // Own copy of the settings and of both axis timers.
    int dz_limit    = int'(DEADZONE_RESET);
    int first_delay = int'(INITIAL_RESET);
    int rep_delay   = int'(REPEAT_RESET);
    int vert_ticks  = 0;
    int horiz_ticks = 0;

    int fail_count  = 0;
    int cycle_count = 0;
    int send_gap    = 0;
    int recv_stall  = 0;
    bit burst_mode  = 1'b0;

    stick_auto_repeat_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Cycle counter and run timeout.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_stick_auto_repeat_top failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
    endtask

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // One axis: press, hold with countdown, reversal and dead zone.
    function automatic axis_next_t advance_axis(input int v, input int stp, input int timer);
        axis_next_t r;
        r.timer = 16'(timer);
        r.pos = 1'b0;
        r.neg = 1'b0;
        if (v >= dz_limit) begin
            if (timer > 0) begin
                r.timer = 16'(timer - stp);
                if (timer - stp <= 0) begin
                    r.timer = 16'(rep_delay);
                    r.pos = 1'b1;
                end
            end else begin
                r.timer = 16'(first_delay);
                r.pos = 1'b1;
            end
        end else if (v <= -dz_limit) begin
            if (timer < 0) begin
                r.timer = 16'(timer + stp);
                if (timer + stp >= 0) begin
                    r.timer = 16'(-rep_delay);
                    r.neg = 1'b1;
                end
            end else begin
                r.timer = 16'(-first_delay);
                r.neg = 1'b1;
            end
        end else begin
            r.timer = '0;
        end
        return r;
    endfunction

    // Predicts the outputs of one frame and advances both timers.
    function automatic sar_out_t predict_frame_outputs(input sar_in_t f);
        sar_out_t   o;
        axis_next_t ny;
        axis_next_t nx;
        ny = advance_axis(int'($signed(f.stick_y)), int'(f.step), vert_ticks);
        nx = advance_axis(int'($signed(f.stick_x)), int'(f.step), horiz_ticks);
        vert_ticks  = int'($signed(ny.timer));
        horiz_ticks = int'($signed(nx.timer));
        o.button_hi   = f.buttons[BTN_HI_BIT];
        o.button_mid  = f.buttons[BTN_MID_BIT];
        o.button_lo   = f.buttons[BTN_LO_BIT];
        o.pulse_up    = ny.pos;
        o.pulse_down  = ny.neg;
        o.pulse_left  = nx.neg;
        o.pulse_right = nx.pos;
        return o;
    endfunction

    // Driver: predicts on each accepted transaction, then offers the next frame.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                predicted_outputs.push_back(predict_frame_outputs(s_data));
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (frames_to_send.size() != 0) begin
                s_data <= frames_to_send.pop_front();
                s_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        sar_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_outputs.size() == 0) begin
                    report_mismatch("result transaction with no frame outstanding");
                end else begin
                    want = predicted_outputs.pop_front();
                    check_field("button_hi", m_data.button_hi, want.button_hi);
                    check_field("button_mid", m_data.button_mid, want.button_mid);
                    check_field("button_lo", m_data.button_lo, want.button_lo);
                    check_field("pulse_up", m_data.pulse_up, want.pulse_up);
                    check_field("pulse_down", m_data.pulse_down, want.pulse_down);
                    check_field("pulse_left", m_data.pulse_left, want.pulse_left);
                    check_field("pulse_right", m_data.pulse_right, want.pulse_right);
                end
            end
            if (recv_stall > 0) begin
                m_ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else begin
                m_ready <= 1'b1;
                recv_stall <= pick_gap();
            end
        end
    end

    task automatic queue_frame(input logic [15:0] b, input int x, input int y, input int st);
        sar_in_t f;
        f.buttons = b;
        f.stick_x = x[7:0];
        f.stick_y = y[7:0];
        f.step    = st[3:0];
        frames_to_send.push_back(f);
    endtask

    // Waits until the sender is empty and every predicted output has arrived.
    task automatic wait_for_drain();
        do @(negedge aclk);
        while (frames_to_send.size() != 0 || s_valid || predicted_outputs.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // Writes all three registers on consecutive cycles.
    task automatic load_settings(input int lim, input int first, input int rep);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DEADZONE_LIMIT;
        cfg_wdata <= lim[6:0];
        @(posedge aclk);
        cfg_index <= CFG_INITIAL_DELAY;
        cfg_wdata <= first[6:0];
        @(posedge aclk);
        cfg_index <= CFG_REPEAT_DELAY;
        cfg_wdata <= rep[6:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        dz_limit = lim;
        first_delay = first;
        rep_delay = rep;
    endtask

    function automatic int pick_setting();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 127;
            2: return 1;
            default: return $urandom_range(1, 127);
        endcase
    endfunction

    // Axis value in a region: 0 dead zone, 1 positive, 2 negative, 3 near the limit.
    function automatic int axis_sample(input int region);
        case (region)
            0: return (dz_limit <= 1) ? 0 : $urandom_range(0, 2 * dz_limit - 2) - (dz_limit - 1);
            1: return $urandom_range(dz_limit, 127);
            2: return -$urandom_range(dz_limit, 128);
            default: begin
                case ($urandom_range(0, 3))
                    0: return dz_limit;
                    1: return -dz_limit;
                    2: return dz_limit - 1;
                    default: return 1 - dz_limit;
                endcase
            end
        endcase
    endfunction

    // Mostly held stick positions with random content, the rest pure noise.
    task automatic queue_random_frames(input int count);
        int n;
        int run_len;
        int x_region;
        int y_region;
        int step_hi;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_frame(16'($urandom), $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 15));
                n++;
            end else begin
                run_len  = $urandom_range(1, 24);
                x_region = $urandom_range(0, 3);
                y_region = $urandom_range(0, 3);
                step_hi  = $urandom_range(0, 15);
                for (int i = 0; i < run_len && n < count; i++) begin
                    queue_frame(16'($urandom), axis_sample(x_region), axis_sample(y_region),
                                $urandom_range(0, step_hi));
                    n++;
                end
            end
        end
    endtask

    // Stimulus sequence: directed frames, then random phases under changing settings.
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: press, countdown, zero step, exact expiry, reversal, dead zone.
        queue_frame(16'h0000, 0, 0, 0);
        queue_frame(16'hFFFF, 127, 127, 15);
        queue_frame(16'h8000, 31, 31, 15);
        queue_frame(16'h4000, 31, 31, 0);
        queue_frame(16'h1000, 127, 127, 15);
        queue_frame(16'h6FFF, 127, 127, 10);
        queue_frame(16'h0000, -128, -128, 5);
        queue_frame(16'hA5A5, -31, -31, 15);
        queue_frame(16'h5A5A, -31, -31, 15);
        queue_frame(16'hFFFF, -30, 30, 15);
        queue_frame(16'h0000, 30, -30, 15);
        queue_frame(16'h0000, -31, 31, 1);
        queue_frame(16'h0000, 31, -31, 1);
        wait_for_drain();

        // Empty dead zone and zero delays: a pulse on every frame.
        load_settings(0, 0, 0);
        queue_frame(16'h0000, 0, 0, 0);
        queue_frame(16'h0000, 0, 0, 0);
        queue_frame(16'h0000, -1, -1, 0);
        queue_frame(16'h0000, -1, -1, 15);
        queue_frame(16'h0000, -128, 127, 3);
        wait_for_drain();

        // Largest settings.
        load_settings(127, 127, 127);
        queue_frame(16'h0000, 127, -127, 15);
        queue_frame(16'h0000, 126, -126, 15);
        queue_frame(16'h0000, -128, 127, 15);
        queue_frame(16'h0000, -127, 127, 15);
        queue_frame(16'h0000, -127, 127, 15);
        queue_frame(16'h0000, -127, 127, 15);
        queue_frame(16'h0000, -127, 127, 15);
        wait_for_drain();

        // Random phases; the sender waits for every output between phases.
        for (int p = 0; p < 6; p++) begin
            if (p == 0)
                load_settings(1, 1, 1);
            else
                load_settings(pick_setting(), pick_setting(), pick_setting());
            burst_mode = (p == 1 || p == 4);
            queue_random_frames(125);
            wait_for_drain();
        end

        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_stick_auto_repeat_top passed");
        else
            $display("tb_stick_auto_repeat_top failed");
        $finish;
    end

endmodule
